// File: src/u8lc_pkg.sv
// ----------------------------------------------------------------------------
// u8lc_pkg
// Shared types, constants and helpers of the UTF-8 decoder with line and
// column tracking.
// ----------------------------------------------------------------------------
package u8lc_pkg;

    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 20;

    localparam int CP_BITS  = 21;
    localparam int POS_BITS = 20;

    localparam logic [CP_BITS-1:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [CP_BITS-1:0] CP_LIMIT       = 21'h110000;
    localparam logic [CP_BITS-1:0] NEWLINE_CP     = 21'h00000A;

    localparam logic [7:0] LEAD2_MIN   = 8'hC0;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] INVALID_MIN = 8'hF8;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;

    localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
    localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;

    typedef struct packed {
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] column;
    } pos_t;

    typedef struct packed {
        logic [CP_BITS-1:0] partial_value;
        logic [1:0]         bytes_remaining;
        logic               holding;
        pos_t               pos;
    } dec_state_t;

    typedef struct packed {
        logic [CP_BITS-1:0]  code_point;
        logic                replaced;
        logic [POS_BITS-1:0] line_number;
        logic [POS_BITS-1:0] column_number;
        logic                end_of_text;
        logic                last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
        dec_state_t next_state;
    } dec_out_t;

    // Position after a character: a newline opens the next line at column 1,
    // anything else moves one column on; the end-of-text marker stays put.
    function automatic pos_t pos_advance(pos_t p, logic [CP_BITS-1:0] cp, logic eot);
        pos_t q;
        q = p;
        if (!eot) begin
            if (cp == NEWLINE_CP) begin
                if (p.line != LINE_MAX) begin
                    q.line = p.line + 1'b1;
                end
                q.column = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
            end
            else if (p.column != COLUMN_MAX) begin
                q.column = p.column + 1'b1;
            end
        end
        return q;
    endfunction

endpackage

// File: src/u8lc_decode.sv
// ----------------------------------------------------------------------------
// u8lc_decode
// Single-pass decode of one byte against the held sequence state; yields up
// to two results with their positions and the next state.
// ----------------------------------------------------------------------------
module u8lc_decode (
    input  logic [7:0]           text_byte,
    input  u8lc_pkg::dec_state_t state,
    output u8lc_pkg::dec_out_t   dec
);
    import u8lc_pkg::*;

    logic               is_cont;
    logic               is_lead;
    logic               absorb;
    logic               held_emit;
    logic               byte_emit;
    logic [CP_BITS-1:0] held_cp;
    logic               held_repl;
    logic [CP_BITS-1:0] byte_cp;
    logic               byte_repl;
    logic               byte_eot;
    result_t            r_first;
    result_t            r_second;
    pos_t               pos1;
    pos_t               pos2;
    dec_state_t         nxt;

    always_comb
    begin
        is_cont   = (text_byte[7:6] == 2'b10);
        is_lead   = (text_byte >= LEAD2_MIN) && (text_byte < INVALID_MIN);
        absorb    = state.holding && is_cont && (state.bytes_remaining != 2'd0);
        held_emit = state.holding && !absorb;
        byte_emit = !absorb && !is_lead;

        // A continuation after a full sequence, a truncation or a value past the code space voids the held character.
        if (is_cont || (state.bytes_remaining != 2'd0) || (state.partial_value >= CP_LIMIT))
        begin
            held_cp   = REPLACEMENT_CP;
            held_repl = 1'b1;
        end
        else
        begin
            held_cp   = state.partial_value;
            held_repl = 1'b0;
        end

        byte_eot = (text_byte == 8'h00);
        if (text_byte < ASCII_LIMIT)
        begin
            byte_cp   = {{(CP_BITS-8){1'b0}}, text_byte};
            byte_repl = 1'b0;
        end
        else
        begin
            byte_cp   = REPLACEMENT_CP;
            byte_repl = 1'b1;
        end

        r_first  = '0;
        r_second = '0;
        if (held_emit)
        begin
            r_first.code_point = held_cp;
            r_first.replaced   = held_repl;
        end
        else
        begin
            r_first.code_point  = byte_cp;
            r_first.replaced    = byte_repl;
            r_first.end_of_text = byte_eot;
        end
        r_second.code_point  = byte_cp;
        r_second.replaced    = byte_repl;
        r_second.end_of_text = byte_eot;

        pos1 = pos_advance(state.pos, r_first.code_point, r_first.end_of_text);
        pos2 = pos_advance(pos1, r_second.code_point, r_second.end_of_text);

        r_first.line_number    = POS_BITS'(state.pos.line);
        r_first.column_number  = POS_BITS'(state.pos.column);
        r_second.line_number   = POS_BITS'(pos1.line);
        r_second.column_number = POS_BITS'(pos1.column);

        dec.count = {1'b0, held_emit} + {1'b0, byte_emit};
        r_first.last_of_run  = (dec.count == 2'd1);
        r_second.last_of_run = 1'b1;

        nxt = state;
        if (absorb)
        begin
            nxt.partial_value   = {state.partial_value[CP_BITS-7:0], text_byte[5:0]};
            nxt.bytes_remaining = state.bytes_remaining - 2'd1;
            nxt.holding         = 1'b1;
        end
        else if (is_lead)
        begin
            nxt.holding = 1'b1;
            if (text_byte >= LEAD4_MIN)
            begin
                nxt.partial_value   = {{(CP_BITS-3){1'b0}}, text_byte[2:0]};
                nxt.bytes_remaining = 2'd3;
            end
            else if (text_byte >= LEAD3_MIN)
            begin
                nxt.partial_value   = {{(CP_BITS-4){1'b0}}, text_byte[3:0]};
                nxt.bytes_remaining = 2'd2;
            end
            else
            begin
                nxt.partial_value   = {{(CP_BITS-5){1'b0}}, text_byte[4:0]};
                nxt.bytes_remaining = 2'd1;
            end
        end
        else
        begin
            nxt.holding         = 1'b0;
            nxt.partial_value   = '0;
            nxt.bytes_remaining = 2'd0;
        end

        case (dec.count)
            2'd1:    nxt.pos = pos1;
            2'd2:    nxt.pos = pos2;
            default: nxt.pos = state.pos;
        endcase

        dec.first      = r_first;
        dec.second     = r_second;
        dec.next_state = nxt;
    end

endmodule

// File: src/utf8_decoder_line_col_unit.sv
// ----------------------------------------------------------------------------
// utf8_decoder_line_col_unit
// UTF-8 decoder that reports, for every character, the line and column
// where it starts.
// ----------------------------------------------------------------------------
// Results: the results of a byte are written into the result queue when it
// is transferred in and reach the output from its head; a second result of
// the same byte follows the first. Throughput: one byte per cycle unless
// stalled, bounded by the single output port when bytes give two results;
// the four-entry result queue sets the stall.
// Reset: rst_n clears the sequence state, empties the queue and sets the
// position to line 1, column 1.
// ----------------------------------------------------------------------------
module utf8_decoder_line_col_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   text_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [u8lc_pkg::CP_BITS-1:0]  code_point,
    output logic                         replaced,
    output logic [u8lc_pkg::POS_BITS-1:0] line_number,
    output logic [u8lc_pkg::POS_BITS-1:0] column_number,
    output logic                         end_of_text,
    output logic                         last_of_run
);
    import u8lc_pkg::*;

    // The decoder state lives in one register. Each transferred byte is
    // decoded in a single pass and its results are written into a small
    // circular queue whose head drives the output ports directly.
    dec_state_t state_reg;
    dec_state_t state_next;
    dec_out_t   dec;

    result_t    queue_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       in_xfer;
    logic       out_xfer;
    logic [2:0] push_count;
    result_t    head;

    u8lc_decode u_decode (
        .text_byte (text_byte),
        .state     (state_reg),
        .dec       (dec)
    );

    // With at most two entries occupied there is room for the two results
    // a single byte can produce, so the stall depends on registers only.
    assign in_stall  = (count_reg > 3'd2);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = (count_reg != 3'd0);
    assign out_xfer  = out_valid && !out_stall;

    always_comb
    begin
        push_count  = in_xfer ? {1'b0, dec.count} : 3'd0;
        state_next  = in_xfer ? dec.next_state : state_reg;
        wr_ptr_next = wr_ptr_reg + push_count[1:0];
        rd_ptr_next = rd_ptr_reg + {1'b0, out_xfer};
        count_next  = count_reg + push_count - {2'b00, out_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.partial_value   <= '0;
            state_reg.bytes_remaining <= 2'd0;
            state_reg.holding         <= 1'b0;
            state_reg.pos.line        <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            state_reg.pos.column      <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
            wr_ptr_reg                <= 2'd0;
            rd_ptr_reg                <= 2'd0;
            count_reg                 <= 3'd0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload carries no reset; only the pointers and count matter.
    always_ff @(posedge clk)
    begin
        if (in_xfer && (dec.count != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= dec.first;
        end
        if (in_xfer && (dec.count == 2'd2))
        begin
            queue_reg[wr_ptr_reg + 2'd1] <= dec.second;
        end
    end

    assign head          = queue_reg[rd_ptr_reg];
    assign code_point    = head.code_point;
    assign replaced      = head.replaced;
    assign line_number   = head.line_number;
    assign column_number = head.column_number;
    assign end_of_text   = head.end_of_text;
    assign last_of_run   = head.last_of_run;

    // The queue never holds more than its four entries.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 3'd4)
        else $error("result queue overflow");

    // The pointer distance always agrees with the occupancy count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[1:0])
        else $error("queue pointers disagree with count");

    // A zero byte flushes any held sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (text_byte == 8'h00)) |=> !state_reg.holding)
        else $error("sequence still held after end of text");

    // Positions start at one and never fall to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.pos.line != '0) && (state_reg.pos.column != '0))
        else $error("line or column counter reached zero");

endmodule

// File: bench/utf8_line_col_checker.sv
// ----------------------------------------------------------------------------
// utf8_line_col_checker
// Watches both channels of the UTF-8 line/column decoder. Every byte that is
// transferred in is decoded by a behavioral copy of the decoder, and the
// characters it yields are queued. Every result transferred out is checked
// field by field against the oldest queued character.
// ----------------------------------------------------------------------------
module utf8_line_col_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [7:0]                    text_byte,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [u8lc_pkg::CP_BITS-1:0]  code_point,
    input  logic                          replaced,
    input  logic [u8lc_pkg::POS_BITS-1:0] line_number,
    input  logic [u8lc_pkg::POS_BITS-1:0] column_number,
    input  logic                          end_of_text,
    input  logic                          last_of_run,
    output int                            mismatches,
    output int                            chars_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import u8lc_pkg::*;

    // Decoder state of the behavioral copy.
    logic [CP_BITS-1:0]     seq_value = '0;
    logic [1:0]             seq_left  = '0;
    logic                   seq_held  = 1'b0;
    logic [LINE_BITS-1:0]   cur_line  = LINE_BITS'(1);
    logic [COLUMN_BITS-1:0] cur_col   = COLUMN_BITS'(1);

    result_t expected_chars[$];

    // Queue one character at the current position, then move the position.
    task automatic emit_char(input logic [CP_BITS-1:0] cp, input logic repl, input logic eot);
        result_t r;
        r.code_point    = cp;
        r.replaced      = repl;
        r.line_number   = cur_line[POS_BITS-1:0];
        r.column_number = cur_col[POS_BITS-1:0];
        r.end_of_text   = eot;
        r.last_of_run   = 1'b0;
        expected_chars.push_back(r);
        if (!eot) begin
            if (cp == NEWLINE_CP) begin
                if (cur_line != LINE_MAX) begin
                    cur_line = cur_line + 1'b1;
                end
                cur_col = COLUMN_BITS'(1);
            end
            else if (cur_col != COLUMN_MAX) begin
                cur_col = cur_col + 1'b1;
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic    is_cont;
        int      produced;
        result_t r;
        is_cont  = (b >= ASCII_LIMIT) && (b < LEAD2_MIN);
        produced = 0;
        if (seq_held && is_cont && seq_left != 2'd0) begin
            seq_value = {seq_value[CP_BITS-7:0], b[5:0]};
            seq_left  = seq_left - 1'b1;
        end
        else begin
            if (seq_held) begin
                // A continuation after a complete sequence, a truncated sequence or a
                // value past the code space voids the held character; otherwise it is flushed.
                if (is_cont || seq_left != 2'd0 || seq_value >= CP_LIMIT) begin
                    emit_char(REPLACEMENT_CP, 1'b1, 1'b0);
                end
                else begin
                    emit_char(seq_value, 1'b0, 1'b0);
                end
                produced++;
                seq_held  = 1'b0;
                seq_value = '0;
                seq_left  = '0;
            end
            if (b == 8'h00) begin
                emit_char('0, 1'b0, 1'b1);
                produced++;
            end
            else if (b < ASCII_LIMIT) begin
                emit_char(CP_BITS'(b), 1'b0, 1'b0);
                produced++;
            end
            else if (b >= INVALID_MIN || is_cont) begin
                emit_char(REPLACEMENT_CP, 1'b1, 1'b0);
                produced++;
            end
            else begin
                seq_held = 1'b1;
                if (b >= LEAD4_MIN) begin
                    seq_value = CP_BITS'(b[2:0]);
                    seq_left  = 2'd3;
                end
                else if (b >= LEAD3_MIN) begin
                    seq_value = CP_BITS'(b[3:0]);
                    seq_left  = 2'd2;
                end
                else begin
                    seq_value = CP_BITS'(b[4:0]);
                    seq_left  = 2'd1;
                end
            end
            if (produced > 0) begin
                r = expected_chars[expected_chars.size()-1];
                r.last_of_run = 1'b1;
                expected_chars[expected_chars.size()-1] = r;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            seq_value = '0;
            seq_left  = '0;
            seq_held  = 1'b0;
            cur_line  = LINE_BITS'(1);
            cur_col   = COLUMN_BITS'(1);
            expected_chars.delete();
        end
        else begin
            if (in_valid && !in_stall) begin
                decode_byte(text_byte);
            end
            if (out_valid && !out_stall) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected result: code_point 0x%0h with nothing pending",
                           code_point);
                    mismatches++;
                end
                else begin
                    want = expected_chars.pop_front();
                    check_field("code_point", 32'(want.code_point), 32'(code_point));
                    check_field("replaced", 32'(want.replaced), 32'(replaced));
                    check_field("line_number", 32'(want.line_number), 32'(line_number));
                    check_field("column_number", 32'(want.column_number),
                                32'(column_number));
                    check_field("end_of_text", 32'(want.end_of_text), 32'(end_of_text));
                    check_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
                end
            end
        end
        chars_pending = expected_chars.size();
    end

endmodule

// File: bench/tb_utf8_decoder_line_col_unit.sv
// ----------------------------------------------------------------------------
// tb_utf8_decoder_line_col_unit
// Top-level bench of the UTF-8 decoder with line and column tracking. It
// feeds a directed byte string followed by randomly built UTF-8 text, drives
// random stalls on the result side, and leaves all checking to the checker.
// ----------------------------------------------------------------------------
module tb_utf8_decoder_line_col_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import u8lc_pkg::*;

    localparam int RANDOM_BYTES = 1950;
    localparam int CYCLE_LIMIT  = 200000;
    // The result side holds off this long once, after this many transfers.
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 120;
    localparam int N_DIRECTED   = 25;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          text_byte;
    logic                out_valid;
    logic                out_stall;
    logic [CP_BITS-1:0]  code_point;
    logic                replaced;
    logic [POS_BITS-1:0] line_number;
    logic [POS_BITS-1:0] column_number;
    logic                end_of_text;
    logic                last_of_run;

    int mismatches;
    int chars_pending;
    int cycle_count = 0;
    int bytes_sent  = 0;
    bit tx_burst    = 1'b0;

    // The directed string walks through the special cases in order:
    // plain ASCII and its top value, a newline, an overlong NUL that is
    // flushed by an invalid lead, a continuation after a complete two-byte
    // character, a truncated three-byte sequence, a four-byte value above
    // the code space, a surrogate flushed by a stray continuation, a valid
    // four-byte character, and the end of text while that character is held.
    logic [7:0] directed_bytes [N_DIRECTED] = '{
        8'h41, 8'h7F, 8'h0A,
        8'hC0, 8'h80, 8'hF8,
        8'hC3, 8'hA9, 8'h80,
        8'hE2, 8'h82, 8'h41,
        8'hF7, 8'hBF, 8'hBF, 8'hBF,
        8'hED, 8'hA0, 8'h80, 8'hBF,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'h00
    };

    utf8_decoder_line_col_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .text_byte     (text_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_point    (code_point),
        .replaced      (replaced),
        .line_number   (line_number),
        .column_number (column_number),
        .end_of_text   (end_of_text),
        .last_of_run   (last_of_run)
    );

    utf8_line_col_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .text_byte     (text_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_point    (code_point),
        .replaced      (replaced),
        .line_number   (line_number),
        .column_number (column_number),
        .end_of_text   (end_of_text),
        .last_of_run   (last_of_run),
        .mismatches    (mismatches),
        .chars_pending (chars_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // A random continuation byte: 10xxxxxx.
    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Offers one byte after a random idle gap and returns once it has been
    // transferred. Inputs only change on the falling edge; the transfer is
    // observed on the rising edge. When there is no gap, valid simply stays
    // high while the payload moves on to the next byte.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        text_byte <= value;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Result side: a random stall before each transfer, with stretches of no
    // stall at all, and once a long hold-off during which the sender keeps
    // offering bytes so that the decoder fills up and stalls.
    initial
    begin
        int  gap;
        int  taken;
        bit  calm;
        out_stall = 1'b0;
        taken     = 0;
        calm      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 150 == 0)
            begin
                calm = ($urandom_range(0, 2) == 0);
            end
            gap = calm ? 0 : $urandom_range(0, 3);
            if (taken == HOLD_AFTER)
            begin
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            taken++;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int         kind;
        int         run_len;
        int         next_switch;
        logic [7:0] run [4];
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        text_byte = 8'h00;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_bytes[k])
        begin
            send_byte(directed_bytes[k]);
        end

        // Random text: mostly well-formed characters with random content,
        // the rest malformed on purpose. A zero byte now and then ends a text
        // and the next one starts right after it.
        next_switch = 0;
        while (bytes_sent < N_DIRECTED + RANDOM_BYTES)
        begin
            if (bytes_sent >= next_switch)
            begin
                tx_burst    = ($urandom_range(0, 2) == 0);
                next_switch = bytes_sent + 128;
            end
            kind    = $urandom_range(0, 99);
            run_len = 1;
            if (kind < 40)
            begin
                run[0] = 8'($urandom_range(1, 127));
            end
            else if (kind < 48)
            begin
                run[0] = 8'h0A;
            end
            else if (kind < 62)
            begin
                run[0]  = 8'hC0 | 8'($urandom_range(0, 31));
                run[1]  = cont_byte();
                run_len = 2;
            end
            else if (kind < 74)
            begin
                run[0]  = 8'hE0 | 8'($urandom_range(0, 15));
                run[1]  = cont_byte();
                run[2]  = cont_byte();
                run_len = 3;
            end
            else if (kind < 84)
            begin
                // Leads above 0xF4 give values past the code space.
                run[0]  = 8'hF0 | 8'($urandom_range(0, 7));
                run[1]  = cont_byte();
                run[2]  = cont_byte();
                run[3]  = cont_byte();
                run_len = 4;
            end
            else if (kind < 88)
            begin
                run[0] = cont_byte();
            end
            else if (kind < 91)
            begin
                run[0] = 8'hF8 | 8'($urandom_range(0, 7));
            end
            else if (kind < 95)
            begin
                // Truncated sequence: a lead with too few continuations.
                if ($urandom_range(0, 1) == 0)
                begin
                    run[0]  = 8'hE0 | 8'($urandom_range(0, 15));
                    run_len = $urandom_range(1, 2);
                end
                else
                begin
                    run[0]  = 8'hF0 | 8'($urandom_range(0, 7));
                    run_len = $urandom_range(1, 3);
                end
                for (int j = 1; j < run_len; j++)
                begin
                    run[j] = cont_byte();
                end
            end
            else if (kind < 98)
            begin
                // One continuation too many after a two-byte character.
                run[0]  = 8'hC0 | 8'($urandom_range(0, 31));
                run[1]  = cont_byte();
                run[2]  = cont_byte();
                run_len = 3;
            end
            else
            begin
                run[0] = 8'h00;
            end
            for (int j = 0; j < run_len; j++)
            begin
                send_byte(run[j]);
            end
        end

        // A closing zero byte flushes whatever character is still held.
        send_byte(8'h00);
        @(negedge clk);
        in_valid <= 1'b0;

        while (chars_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (mismatches == 0 && chars_pending == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
